FILE: rtl/ucs_pkg.sv
// Package for the URL component splitter: beat types for the request and
// response channels, part tags, status codes and the delimiter characters.
// No dependencies.
`default_nettype none

package ucs_pkg;

   typedef struct packed {
      logic [7:0] url_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] part;
      logic [2:0] status;
      logic       end_of_url;
   } rsp_type;

   // Part tags.
   localparam logic [2:0] PT_DELIM   = 3'd0;
   localparam logic [2:0] PT_SCHEME  = 3'd1;
   localparam logic [2:0] PT_HOST    = 3'd2;
   localparam logic [2:0] PT_PORT    = 3'd3;
   localparam logic [2:0] PT_PATH    = 3'd4;
   localparam logic [2:0] PT_QUERY   = 3'd5;
   localparam logic [2:0] PT_FRAG    = 3'd6;
   localparam logic [2:0] PT_IGNORED = 3'd7;

   // Status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOCOLON = 3'd1;
   localparam logic [2:0] ST_BADCHAR = 3'd2;
   localparam logic [2:0] ST_NOSLASH = 3'd3;
   localparam logic [2:0] ST_NOAUTH  = 3'd4;

   // Characters that delimit the parts.
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

`default_nettype wire

FILE: rtl/url_component_splitter_unit.sv
// URL component splitter, top level: tags each URL byte with its part.
// Depends on ucs_pkg for the beat types, tags, status codes and characters.
//
// One request beat carries one URL byte and a last flag; each yields exactly
// one registered response beat. A new beat is taken in every cycle while the
// skid entry is free: the decode of a byte against the current phase is one
// short step between the phase register and the response register, and a
// one-entry skid buffer behind the response register takes one more beat
// while the response side stalls. The request side stalls only while that
// skid entry is occupied. The status on each beat is the failure known so far
// and is final on the beat that carries end_of_url; after it a new URL begins.
`default_nettype none

module url_component_splitter_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ucs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ucs_pkg::rsp_type      rsp_data
);
   import ucs_pkg::*;

   typedef enum logic [3:0] {
      PH_SCHEME  = 4'd0,
      PH_PENDING = 4'd1,
      PH_SLASH1  = 4'd2,
      PH_SLASH2  = 4'd3,
      PH_HOST    = 4'd4,
      PH_PORT    = 4'd5,
      PH_PATH    = 4'd6,
      PH_QUERY   = 4'd7,
      PH_FRAG    = 4'd8,
      PH_DONE    = 4'd9,
      PH_FAIL    = 4'd10
   } phase_type;

   phase_type  phase_ff, phase_in, phase_mid;
   logic [2:0] error_ff, error_in, error_mid;
   logic [2:0] part;
   logic [2:0] fail_now, fail_end;
   rsp_type    result;
   rsp_type    out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       accept, out_free;

   // Status for a URL that stops in the given phase; ok if it is complete.
   function automatic logic [2:0] end_failure(input phase_type p);
      logic [2:0] f;
      case (p)
         PH_SCHEME, PH_PENDING: f = ST_NOCOLON;
         PH_SLASH1, PH_SLASH2:  f = ST_NOSLASH;
         PH_HOST, PH_PORT:      f = ST_NOAUTH;
         default:               f = ST_OK;
      endcase
      return f;
   endfunction

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign fail_now  = end_failure(phase_ff);

   always_comb begin
      phase_mid = phase_ff;
      error_mid = error_ff;
      part      = PT_IGNORED;
      if (req_data.url_byte == CH_NUL) begin
         if (phase_ff < PH_DONE) begin
            if (fail_now != ST_OK) begin
               error_mid = fail_now;
               phase_mid = PH_FAIL;
            end else begin
               part      = PT_DELIM;
               phase_mid = PH_DONE;
            end
         end
      end else begin
         case (phase_ff)
            PH_SCHEME: begin
               if (req_data.url_byte == CH_COLON) begin
                  part      = PT_DELIM;
                  phase_mid = PH_SLASH1;
               end else if (req_data.url_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
                  part = PT_SCHEME;
               end else begin
                  phase_mid = PH_PENDING;
               end
            end
            PH_PENDING: begin
               if (req_data.url_byte == CH_COLON) begin
                  error_mid = ST_BADCHAR;
                  phase_mid = PH_FAIL;
               end
            end
            PH_SLASH1, PH_SLASH2: begin
               if (req_data.url_byte == CH_SLASH) begin
                  part      = PT_DELIM;
                  phase_mid = (phase_ff == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
               end else begin
                  error_mid = ST_NOSLASH;
                  phase_mid = PH_FAIL;
               end
            end
            PH_HOST: begin
               if (req_data.url_byte == CH_COLON) begin
                  part      = PT_DELIM;
                  phase_mid = PH_PORT;
               end else if (req_data.url_byte == CH_SLASH) begin
                  part      = PT_DELIM;
                  phase_mid = PH_PATH;
               end else begin
                  part = PT_HOST;
               end
            end
            PH_PORT: begin
               if (req_data.url_byte == CH_SLASH) begin
                  part      = PT_DELIM;
                  phase_mid = PH_PATH;
               end else begin
                  part = PT_PORT;
               end
            end
            PH_PATH: begin
               if (req_data.url_byte == CH_QMARK) begin
                  part      = PT_DELIM;
                  phase_mid = PH_QUERY;
               end else if (req_data.url_byte == CH_HASH) begin
                  part      = PT_DELIM;
                  phase_mid = PH_FRAG;
               end else begin
                  part = PT_PATH;
               end
            end
            PH_QUERY: begin
               if (req_data.url_byte == CH_HASH) begin
                  part      = PT_DELIM;
                  phase_mid = PH_FRAG;
               end else begin
                  part = PT_QUERY;
               end
            end
            PH_FRAG: part = PT_FRAG;
            PH_DONE: ;
            default: phase_mid = PH_FAIL;
         endcase
      end

      phase_in = phase_mid;
      error_in = error_mid;
      fail_end = end_failure(phase_mid);
      // A URL that ends before its authority is closed records why.
      if (req_data.last && (phase_mid < PH_DONE) && (fail_end != ST_OK)) begin
         error_in = fail_end;
         phase_in = PH_FAIL;
      end

      result.byte_out   = req_data.url_byte;
      result.part       = part;
      result.status     = error_in;
      result.end_of_url = req_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SCHEME;
         error_ff      <= ST_OK;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_data.last) begin
               phase_ff <= PH_SCHEME;
               error_ff <= ST_OK;
            end else begin
               phase_ff <= phase_in;
               error_ff <= error_in;
            end
         end

         // Skid entry drains first; a new beat lands behind a stalled one.
         if (out_free) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else if (accept) begin
               out_ff       <= result;
               out_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire
